/* src/srm_pkg.sv */
// Shared types and constants for the serial response matcher.
// Holds the matcher state encoding, reply codes and the byte values it looks for.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srm_pkg;

    // matcher states, one per matched prefix; ST_CR and ST_LF are shared by the CMD, AOK and END replies
    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_C    = 4'd1,
        ST_CM   = 4'd2,
        ST_A    = 4'd3,
        ST_AO   = 4'd4,
        ST_CO   = 4'd5,
        ST_CON  = 4'd6,
        ST_E    = 4'd7,
        ST_EN   = 4'd8,
        ST_CR   = 4'd9,
        ST_LF   = 4'd10
    } t_match_state;

    typedef logic [1:0] t_resp_code;

    // reply codes
    localparam t_resp_code CODE_CMD  = 2'd0;
    localparam t_resp_code CODE_AOK  = 2'd1;
    localparam t_resp_code CODE_CONN = 2'd2;
    localparam t_resp_code CODE_END  = 2'd3;

    // byte values
    localparam logic [7:0] CHR_C  = 8'h43;
    localparam logic [7:0] CHR_A  = 8'h41;
    localparam logic [7:0] CHR_E  = 8'h45;
    localparam logic [7:0] CHR_M  = 8'h4D;
    localparam logic [7:0] CHR_O  = 8'h4F;
    localparam logic [7:0] CHR_N  = 8'h4E;
    localparam logic [7:0] CHR_K  = 8'h4B;
    localparam logic [7:0] CHR_D  = 8'h44;
    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_LF = 8'h0A;

endpackage

`default_nettype wire

/* src/serial_response_matcher.sv */
// Top level of the serial response matcher: reply matcher and line collector.
// Depends on srm_pkg for the state encoding, reply codes and byte values.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one received byte per word.
//   Output channel (o_valid / i_ready) gives one result word per input word:
//   reply-done pulse and code in command mode, buffer write (index, byte)
//   and line-done flag in line mode.
//   Configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
//   writes command_mode; write it only while the block is idle (unenforced).
//   Latency: a result is shown the cycle after its byte is accepted.
//   Throughput: one byte per cycle while i_ready is high; matcher state and
//   line index update in the accepting cycle, so the next byte can follow.
//   The result register sits between the channels: while it holds a word
//   that is not taken, o_ready follows i_ready, so a stall on the output
//   holds the input back after one word.
//   Reset (synchronous, active low) selects command mode, puts the matcher
//   in idle, clears the reply code and line index and empties the result
//   register.
`timescale 1ns / 1ps
`default_nettype none

module serial_response_matcher #(
    parameter int MAX_LINE = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // configuration write
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_command_mode,
    // received bytes
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_rx_byte,
    // results
    output logic                o_valid,
    input  wire                 i_ready,
    output logic                o_response_done,
    output srm_pkg::t_resp_code o_response_code,
    output logic                o_store_valid,
    output logic [6:0]          o_store_index,
    output logic [7:0]          o_store_value,
    output logic                o_line_done
);
    import srm_pkg::*;

    localparam int IDX_W = $clog2(MAX_LINE + 1);

    logic             r_command_mode;
    t_match_state     r_state, n_state;
    t_resp_code       r_pending, n_pending;
    logic [IDX_W-1:0] r_line_index, n_line_index;

    logic             accept;
    logic             match_done;
    t_resp_code       match_code;
    logic             is_cr;
    logic [IDX_W+6:0] index_ext;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !o_valid || i_ready;
    assign accept      = i_valid && o_ready;
    assign is_cr       = (i_rx_byte == CHR_CR);

    // matcher next state
    always_comb begin
        n_state = ST_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (i_rx_byte == CHR_C)      n_state = ST_C;
                else if (i_rx_byte == CHR_A) n_state = ST_A;
                else if (i_rx_byte == CHR_E) n_state = ST_E;
            end
            ST_C: begin
                if (i_rx_byte == CHR_M)      n_state = ST_CM;
                else if (i_rx_byte == CHR_O) n_state = ST_CO;
            end
            ST_CM:   if (i_rx_byte == CHR_D)  n_state = ST_CR;
            ST_A:    if (i_rx_byte == CHR_O)  n_state = ST_AO;
            ST_AO:   if (i_rx_byte == CHR_K)  n_state = ST_CR;
            ST_CO:   if (i_rx_byte == CHR_N)  n_state = ST_CON;
            ST_E:    if (i_rx_byte == CHR_N)  n_state = ST_EN;
            ST_EN:   if (i_rx_byte == CHR_D)  n_state = ST_CR;
            ST_CR:   if (i_rx_byte == CHR_CR) n_state = ST_LF;
            default: n_state = ST_IDLE;
        endcase
    end

    // matcher outputs and pending reply code
    always_comb begin
        n_pending  = r_pending;
        match_done = 1'b0;
        match_code = CODE_CMD;
        case (r_state)
            ST_IDLE: n_pending = CODE_CMD;
            ST_CM:   if (i_rx_byte == CHR_D) n_pending = CODE_CMD;
            ST_AO:   if (i_rx_byte == CHR_K) n_pending = CODE_AOK;
            ST_EN:   if (i_rx_byte == CHR_D) n_pending = CODE_END;
            ST_CON: begin
                if (i_rx_byte == CHR_N) begin
                    n_pending  = CODE_CONN;
                    match_done = 1'b1;
                    match_code = CODE_CONN;
                end
            end
            ST_LF: begin
                if (i_rx_byte == CHR_LF) begin
                    match_done = 1'b1;
                    match_code = r_pending;
                end
            end
            default: n_pending = r_pending;
        endcase
    end

    // line index: cleared by cr, saturates at the buffer size
    always_comb begin
        if (is_cr)
            n_line_index = '0;
        else if (r_line_index < IDX_W'(MAX_LINE))
            n_line_index = r_line_index + 1'b1;
        else
            n_line_index = r_line_index;
    end

    assign index_ext = {7'd0, r_line_index};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_mode <= 1'b1;
            r_state        <= ST_IDLE;
            r_pending      <= CODE_CMD;
            r_line_index   <= '0;
            o_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                r_command_mode <= i_cfg_command_mode;
            if (accept) begin
                if (r_command_mode) begin
                    r_state   <= n_state;
                    r_pending <= n_pending;
                end else begin
                    r_line_index <= n_line_index;
                end
            end
            if (accept)
                o_valid <= 1'b1;
            else if (i_ready)
                o_valid <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_command_mode) begin
                o_response_done <= match_done;
                o_response_code <= match_code;
                o_store_valid   <= 1'b0;
                o_store_index   <= 7'd0;
                o_store_value   <= 8'd0;
                o_line_done     <= 1'b0;
            end else begin
                o_response_done <= 1'b0;
                o_response_code <= CODE_CMD;
                o_store_valid   <= 1'b1;
                o_store_index   <= index_ext[6:0];
                o_store_value   <= is_cr ? 8'd0 : i_rx_byte;
                o_line_done     <= is_cr;
            end
        end
    end

endmodule

`default_nettype wire

/* src/srm_checker.sv */
// Port-level checks for the serial response matcher, bound to the top level.
// Depends on srm_pkg for the reply code type.
`timescale 1ns / 1ps
`default_nettype none

module srm_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_valid,
    input wire                 o_response_done,
    input srm_pkg::t_resp_code o_response_code,
    input wire                 o_store_valid,
    input wire [6:0]           o_store_index,
    input wire [7:0]           o_store_value,
    input wire                 o_line_done
);
    import srm_pkg::*;

    // result register empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid right after reset");

    // a word is either a reply report or a buffer write
    a_one_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_response_done && o_store_valid))
        else $error("reply and buffer write in one word");

    // no code without a completed reply
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_response_done) |-> (o_response_code == CODE_CMD))
        else $error("reply code set without reply done");

    // buffer fields quiet when nothing is written
    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_store_valid) |->
            (o_store_index == 7'd0 && o_store_value == 8'd0 && !o_line_done))
        else $error("buffer fields set without a buffer write");

    // line end writes the terminator
    a_terminator: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_done) |-> (o_store_valid && o_store_value == 8'd0))
        else $error("line end without zero terminator");

endmodule

bind serial_response_matcher srm_checker u_srm_checker (.*);

`default_nettype wire
